/* hdl/bms_info_frame_checker_defines.svh */
`ifndef BMS_INFO_FRAME_CHECKER_DEFINES_SVH
`define BMS_INFO_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BIFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BIFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/bifc_pkg.sv */
`default_nettype none
package bifc_pkg;

  localparam int DEF_FRAME_BYTES = 34;

  localparam int SUM_FIRST   = 2;
  localparam int FIELD_FIRST = 4;
  localparam int FIELD_COUNT = 8;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int LIMIT_W = 20;
  localparam int MEAS_W  = 20;

  localparam logic [7:0] START_RST  = 8'hDD;
  localparam logic [7:0] STOP_RST   = 8'h77;
  localparam logic [7:0] STATUS_ERR = 8'h80;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_ERR_STAT  = 3'd3;
  localparam logic [2:0] ST_CHECKSUM  = 3'd4;
  localparam logic [2:0] ST_BAD_STOP  = 3'd5;

  localparam logic [1:0] REG_START     = 2'd0;
  localparam logic [1:0] REG_STOP      = 2'd1;
  localparam logic [1:0] REG_CHG_LIMIT = 2'd2;
  localparam logic [1:0] REG_DIS_LIMIT = 2'd3;

  typedef logic [FIELD_COUNT-1:0][7:0] field_bytes_t;

  typedef struct packed {
    logic [2:0]   code;
    field_bytes_t fields;
  } frame_rec_t;

endpackage
`default_nettype wire

/* hdl/bifc_front.sv */
`default_nettype none
module bifc_front
  import bifc_pkg::*;
#(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_frame_end,
  input  wire logic [7:0] start_marker,
  input  wire logic [7:0] stop_marker,
  input  wire logic       q_full,
  output logic            q_push,
  output frame_rec_t      q_data
);

  localparam int CW        = $clog2(FRAME_BYTES + 2);
  localparam int SUM_LAST  = FRAME_BYTES - 4;
  localparam int CSUM_HI   = FRAME_BYTES - 3;
  localparam int CSUM_LO   = FRAME_BYTES - 2;
  localparam int COUNT_MAX = FRAME_BYTES + 1;

  logic [CW-1:0] count_r, count_nxt, count_inc;
  logic [15:0]   sum_r, sum_nxt, sum_add;
  logic [7:0]    first_r, first_nxt;
  logic [7:0]    status_r, status_nxt;
  logic [15:0]   csum_r, csum_nxt;
  field_bytes_t  field_r, field_nxt;
  logic [2:0]    code;
  logic          accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    count_inc  = (count_r < CW'(COUNT_MAX)) ? CW'(count_r + 1'b1) : count_r;
    first_nxt  = (count_r == CW'(0)) ? in_rx_byte : first_r;
    status_nxt = (count_r == CW'(SUM_FIRST)) ? in_rx_byte : status_r;
    sum_add    = sum_r;
    if (count_r >= CW'(SUM_FIRST) && count_r <= CW'(SUM_LAST)) begin
      sum_add = sum_r + {8'd0, in_rx_byte};
    end
    csum_nxt = csum_r;
    if (count_r == CW'(CSUM_HI)) begin
      csum_nxt[15:8] = in_rx_byte;
    end
    if (count_r == CW'(CSUM_LO)) begin
      csum_nxt[7:0] = in_rx_byte;
    end
    field_nxt = field_r;
    for (int k = 0; k < FIELD_COUNT; k++) begin
      if (count_r == CW'(FIELD_FIRST + k)) begin
        field_nxt[k] = in_rx_byte;
      end
    end
    if (count_inc != CW'(FRAME_BYTES)) begin
      code = ST_BAD_LEN;
    end else if (first_nxt != start_marker) begin
      code = ST_BAD_START;
    end else if (status_nxt == STATUS_ERR) begin
      code = ST_ERR_STAT;
    end else if (csum_nxt != 16'(-sum_add)) begin
      code = ST_CHECKSUM;
    end else if (in_rx_byte != stop_marker) begin
      code = ST_BAD_STOP;
    end else begin
      code = ST_OK;
    end
    count_nxt = in_frame_end ? '0 : count_inc;
    sum_nxt   = in_frame_end ? 16'd0 : sum_add;
  end

  assign q_push        = accept && in_frame_end;
  assign q_data.code   = code;
  assign q_data.fields = field_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r  <= first_nxt;
      status_r <= status_nxt;
      csum_r   <= csum_nxt;
      field_r  <= field_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/bifc_queue.sv */
`default_nettype none
`include "bms_info_frame_checker_defines.svh"
module bifc_queue
  import bifc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire frame_rec_t  push_data,
  output logic             full,
  input  wire logic        pop,
  output frame_rec_t       pop_data,
  output logic             empty
);

  frame_rec_t         slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = Q_CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = Q_CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= Q_PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= Q_PTR_W'(rd_ptr_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `BIFC_ASSERT_IMP(a_push_not_full, push, !full, "frame pushed into full queue")
  `BIFC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= Q_CNT_W'(Q_DEPTH), "queue count out of range")
  `BIFC_ASSERT_NXT(a_push_count, do_push && !do_pop, cnt_r == Q_CNT_W'($past(cnt_r) + 1'b1),
                   "queue count missed a push")

endmodule
`default_nettype wire

/* hdl/bifc_back.sv */
`default_nettype none
`include "bms_info_frame_checker_defines.svh"
module bifc_back
  import bifc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire frame_rec_t          q_data,
  output logic                     q_pop,
  input  wire logic [LIMIT_W-1:0]  charge_limit,
  input  wire logic [LIMIT_W-1:0]  discharge_limit,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_frame_ok,
  output logic [2:0]               out_status_code,
  output logic [MEAS_W-1:0]        out_pack_volt,
  output logic signed [MEAS_W-1:0] out_pack_curr,
  output logic [MEAS_W-1:0]        out_remain_cap,
  output logic [MEAS_W-1:0]        out_full_cap,
  output logic [LIMIT_W-1:0]       out_charge_limit_out_ma,
  output logic [LIMIT_W-1:0]       out_discharge_limit_out_ma
);

  function automatic logic [MEAS_W-1:0] times10(input logic [MEAS_W-1:0] x);
    times10 = MEAS_W'({x, 3'b000}) + MEAS_W'({x, 1'b0});
  endfunction

  logic              out_valid_r, out_valid_nxt;
  logic              ok;
  logic [15:0]       raw_v, raw_i, raw_c, raw_f;
  logic [MEAS_W-1:0] volt_nxt, cur_nxt, cap_nxt, full_nxt;

  assign out_valid = out_valid_r;
  assign q_pop     = !q_empty && (!out_valid_r || !out_stall);
  assign ok        = (q_data.code == ST_OK);

  always_comb begin
    raw_v    = {q_data.fields[0], q_data.fields[1]};
    raw_i    = {q_data.fields[2], q_data.fields[3]};
    raw_c    = {q_data.fields[4], q_data.fields[5]};
    raw_f    = {q_data.fields[6], q_data.fields[7]};
    volt_nxt = ok ? times10({4'd0, raw_v}) : '0;
    cur_nxt  = ok ? times10({{4{raw_i[15]}}, raw_i}) : '0;
    cap_nxt  = ok ? times10({4'd0, raw_c}) : '0;
    full_nxt = ok ? times10({4'd0, raw_f}) : '0;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_frame_ok               <= ok;
      out_status_code            <= q_data.code;
      out_pack_volt              <= volt_nxt;
      out_pack_curr              <= cur_nxt;
      out_remain_cap             <= cap_nxt;
      out_full_cap               <= full_nxt;
      out_charge_limit_out_ma    <= charge_limit;
      out_discharge_limit_out_ma <= discharge_limit;
    end
  end

  `BIFC_ASSERT_IMP(a_ok_matches_code, out_valid_r, out_frame_ok == (out_status_code == ST_OK),
                   "frame_ok disagrees with status code")
  `BIFC_ASSERT_IMP(a_fail_zero, out_valid_r && !out_frame_ok,
                   out_pack_volt == '0 && out_pack_curr == '0 &&
                   out_remain_cap == '0 && out_full_cap == '0,
                   "failed frame carries measurements")
  `BIFC_ASSERT_NXT(a_pop_shows, q_pop, out_valid_r, "popped frame not presented")

endmodule
`default_nettype wire

/* hdl/bms_info_frame_checker.sv */
// a frame's result is queued, then loaded into the result register that drives out_valid
// throughput: one byte per cycle; the result register and a 2-entry frame queue
// let bytes keep flowing while a result waits, input stalls only when the queue is full
// reset: synchronous, active low; clears byte count, running sum, queue and result
// valid, and loads the default start/stop markers and zero current limits
`default_nettype none
module bms_info_frame_checker
  import bifc_pkg::*;
#(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_rx_byte,
  input  wire logic                 in_frame_end,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_frame_ok,
  output logic [2:0]                out_status_code,
  output logic [MEAS_W-1:0]         out_pack_volt,
  output logic signed [MEAS_W-1:0]  out_pack_curr,
  output logic [MEAS_W-1:0]         out_remain_cap,
  output logic [MEAS_W-1:0]         out_full_cap,
  output logic [LIMIT_W-1:0]        out_charge_limit_out_ma,
  output logic [LIMIT_W-1:0]        out_discharge_limit_out_ma,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [LIMIT_W-1:0]   cfg_wdata
);

  logic [7:0]         start_r, stop_r;
  logic [LIMIT_W-1:0] chg_r, dis_r;
  logic               q_full, q_push, q_pop, q_empty;
  frame_rec_t         q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      stop_r  <= STOP_RST;
      chg_r   <= '0;
      dis_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START:     start_r <= cfg_wdata[7:0];
        REG_STOP:      stop_r  <= cfg_wdata[7:0];
        REG_CHG_LIMIT: chg_r   <= cfg_wdata;
        REG_DIS_LIMIT: dis_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  bifc_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .in_frame_end (in_frame_end),
    .start_marker (start_r),
    .stop_marker  (stop_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  bifc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  bifc_back u_back (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .q_empty                    (q_empty),
    .q_data                     (q_out),
    .q_pop                      (q_pop),
    .charge_limit               (chg_r),
    .discharge_limit            (dis_r),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_frame_ok               (out_frame_ok),
    .out_status_code            (out_status_code),
    .out_pack_volt              (out_pack_volt),
    .out_pack_curr              (out_pack_curr),
    .out_remain_cap             (out_remain_cap),
    .out_full_cap               (out_full_cap),
    .out_charge_limit_out_ma    (out_charge_limit_out_ma),
    .out_discharge_limit_out_ma (out_discharge_limit_out_ma)
  );

endmodule
`default_nettype wire

/* tb/tb_bms_info_frame_checker.sv */
`timescale 1ns / 1ps

module tb_bms_info_frame_checker
  import bifc_pkg::*;
;

  localparam int FRAME_LEN   = DEF_FRAME_BYTES;
  localparam int CSUM_HI_IDX = FRAME_LEN - 3;
  localparam int CSUM_LO_IDX = FRAME_LEN - 2;
  localparam int SUM_LAST    = FRAME_LEN - 4;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASE_BYTES = 130;

  typedef logic [7:0] byte_q_t[$];

  typedef enum int {
    FR_GOOD, FR_BAD_START, FR_ERR_STATUS, FR_BAD_CSUM, FR_BAD_STOP, FR_SHORT, FR_LONG,
    FR_NOISE
  } frame_kind_t;

  typedef struct {
    logic               ok;
    logic [2:0]         code;
    logic [19:0]        volt;
    logic signed [19:0] cur;
    logic [19:0]        cap;
    logic [19:0]        full;
    logic [19:0]        chg;
    logic [19:0]        dis;
  } frame_result_t;

  class frame_scoreboard;
    logic [7:0]    start_marker;
    logic [7:0]    stop_marker;
    logic [19:0]   chg_limit;
    logic [19:0]   dis_limit;
    int unsigned   byte_cnt;
    logic [15:0]   body_sum;
    logic [7:0]    first_b;
    logic [7:0]    stat_b;
    logic [15:0]   rx_csum;
    logic [7:0]    fld[FIELD_COUNT];
    logic [7:0]    last_b;
    frame_result_t expected_q[$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   passed;

    function new();
      start_marker = START_RST;
      stop_marker  = STOP_RST;
      chg_limit    = '0;
      dis_limit    = '0;
      byte_cnt     = 0;
      body_sum     = '0;
      first_b      = '0;
      stat_b       = '0;
      rx_csum      = '0;
      last_b       = '0;
      foreach (fld[i]) fld[i] = '0;
      errors  = 0;
      checked = 0;
      passed  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] val);
      case (idx)
        REG_START:     start_marker = val[7:0];
        REG_STOP:      stop_marker  = val[7:0];
        REG_CHG_LIMIT: chg_limit    = val;
        REG_DIS_LIMIT: dis_limit    = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // byte accepted by the block
    function void note_byte(logic [7:0] b, logic e);
      frame_result_t r;
      int            cur_s;
      if (byte_cnt == 0) first_b = b;
      if (byte_cnt == SUM_FIRST) stat_b = b;
      if (byte_cnt >= SUM_FIRST && byte_cnt <= SUM_LAST) body_sum = body_sum + 16'(b);
      if (byte_cnt >= FIELD_FIRST && byte_cnt < FIELD_FIRST + FIELD_COUNT)
        fld[byte_cnt - FIELD_FIRST] = b;
      if (byte_cnt == CSUM_HI_IDX) rx_csum[15:8] = b;
      if (byte_cnt == CSUM_LO_IDX) rx_csum[7:0] = b;
      last_b = b;
      if (byte_cnt < FRAME_LEN + 1) byte_cnt++;
      if (!e) return;

      if (byte_cnt != FRAME_LEN) r.code = ST_BAD_LEN;
      else if (first_b != start_marker) r.code = ST_BAD_START;
      else if (stat_b == STATUS_ERR) r.code = ST_ERR_STAT;
      else if (rx_csum != 16'(16'd0 - body_sum)) r.code = ST_CHECKSUM;
      else if (last_b != stop_marker) r.code = ST_BAD_STOP;
      else r.code = ST_OK;

      r.ok   = (r.code == ST_OK);
      r.volt = '0;
      r.cur  = '0;
      r.cap  = '0;
      r.full = '0;
      if (r.ok) begin
        cur_s  = $signed({fld[2], fld[3]});
        r.volt = {fld[0], fld[1]} * 20'd10;
        r.cur  = 20'(cur_s * 10);
        r.cap  = {fld[4], fld[5]} * 20'd10;
        r.full = {fld[6], fld[7]} * 20'd10;
      end
      r.chg = chg_limit;
      r.dis = dis_limit;
      expected_q.insert(expected_q.size(), r);
      byte_cnt = 0;
      body_sum = '0;
    endfunction

    task report(string what, int got, int want);
      errors++;
      if (errors <= 40)
        $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    task compare_field(string what, int got, int want);
      if (got != want) report(what, got, want);
    endtask

    task check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        report("result with no frame pending, status_code", got.code, -1);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.ok) passed++;
      compare_field("frame_ok", got.ok, want.ok);
      compare_field("status_code", got.code, want.code);
      compare_field("pack_volt", got.volt, want.volt);
      compare_field("pack_curr", int'(got.cur), int'(want.cur));
      compare_field("remain_cap", got.cap, want.cap);
      compare_field("full_cap", got.full, want.full);
      compare_field("charge_limit_out_ma", got.chg, want.chg);
      compare_field("discharge_limit_out_ma", got.dis, want.dis);
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               in_frame_end;
  logic               out_valid;
  logic               out_stall;
  logic               out_frame_ok;
  logic [2:0]         out_status_code;
  logic [MEAS_W-1:0]  out_pack_volt;
  logic signed [MEAS_W-1:0] out_pack_curr;
  logic [MEAS_W-1:0]  out_remain_cap;
  logic [MEAS_W-1:0]  out_full_cap;
  logic [LIMIT_W-1:0] out_charge_limit_out_ma;
  logic [LIMIT_W-1:0] out_discharge_limit_out_ma;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [LIMIT_W-1:0] cfg_wdata;

  frame_scoreboard sb = new();
  frame_result_t   seen_result;
  int unsigned     quiet_cycles;
  int unsigned     bytes_sent;
  int unsigned     cfg_settings;
  int              in_idle_pct;
  int              out_idle_pct;
  logic            hold_req;

  bms_info_frame_checker dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_rx_byte                 (in_rx_byte),
    .in_frame_end               (in_frame_end),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_frame_ok               (out_frame_ok),
    .out_status_code            (out_status_code),
    .out_pack_volt              (out_pack_volt),
    .out_pack_curr              (out_pack_curr),
    .out_remain_cap             (out_remain_cap),
    .out_full_cap               (out_full_cap),
    .out_charge_limit_out_ma    (out_charge_limit_out_ma),
    .out_discharge_limit_out_ma (out_discharge_limit_out_ma),
    .cfg_we                     (cfg_we),
    .cfg_index                  (cfg_index),
    .cfg_wdata                  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // input transfers feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_byte(in_rx_byte, in_frame_end);
  end

  // result transfers are checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_result.ok   = out_frame_ok;
      seen_result.code = out_status_code;
      seen_result.volt = out_pack_volt;
      seen_result.cur  = out_pack_curr;
      seen_result.cap  = out_remain_cap;
      seen_result.full = out_full_cap;
      seen_result.chg  = out_charge_limit_out_ma;
      seen_result.dis  = out_discharge_limit_out_ma;
      sb.check_result(seen_result);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, sb.pending());
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
      end
      out_stall = ($urandom_range(99) < out_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_rx_byte   = b;
    in_frame_end = e;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input byte_q_t fr);
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  task automatic seal(inout byte_q_t fr);
    logic [15:0] s;
    s = '0;
    for (int i = SUM_FIRST; i <= SUM_LAST; i++) s = s + 16'(fr[i]);
    s = 16'(16'd0 - s);
    fr[CSUM_HI_IDX] = s[15:8];
    fr[CSUM_LO_IDX] = s[7:0];
  endtask

  task automatic good_frame(output byte_q_t fr);
    int fill;
    fr.delete();
    repeat (FRAME_LEN) fr.insert(fr.size(), 8'($urandom));
    fill = $urandom_range(9);
    for (int i = FIELD_FIRST; i < FIELD_FIRST + FIELD_COUNT; i++) begin
      if (fill == 0) fr[i] = 8'h00;
      else if (fill == 1) fr[i] = 8'hFF;
    end
    fr[0] = sb.start_marker;
    if (fr[SUM_FIRST] == STATUS_ERR) fr[SUM_FIRST] = ~STATUS_ERR;
    fr[FRAME_LEN-1] = sb.stop_marker;
    seal(fr);
  endtask

  task automatic corrupt(input frame_kind_t kind, inout byte_q_t fr);
    logic [15:0] x;
    int          n;
    x = 16'($urandom_range(1, 65535));
    case (kind)
      FR_BAD_START:  fr[0] = fr[0] ^ 8'($urandom_range(1, 255));
      FR_ERR_STATUS: begin
        fr[SUM_FIRST] = STATUS_ERR;
        seal(fr);
      end
      FR_BAD_CSUM: begin
        fr[CSUM_HI_IDX] = fr[CSUM_HI_IDX] ^ x[15:8];
        fr[CSUM_LO_IDX] = fr[CSUM_LO_IDX] ^ x[7:0];
      end
      FR_BAD_STOP: fr[FRAME_LEN-1] = fr[FRAME_LEN-1] ^ 8'($urandom_range(1, 255));
      FR_SHORT: begin
        n = $urandom_range(1, FRAME_LEN - 1);
        while (fr.size() > n) fr.delete(fr.size() - 1);
      end
      FR_LONG: repeat ($urandom_range(1, 8)) fr.insert(fr.size(), 8'($urandom));
      FR_NOISE: begin
        fr.delete();
        repeat ($urandom_range(1, 50)) fr.insert(fr.size(), 8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic send_kind(input frame_kind_t kind);
    byte_q_t fr;
    good_frame(fr);
    corrupt(kind, fr);
    send_frame(fr);
  endtask

  task automatic send_fields(input logic [7:0] f0, input logic [7:0] f1);
    byte_q_t fr;
    good_frame(fr);
    for (int i = FIELD_FIRST; i < FIELD_FIRST + FIELD_COUNT; i++) fr[i] = f1;
    fr[FIELD_FIRST + 2] = f0;
    seal(fr);
    send_frame(fr);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] st, input logic [7:0] sp,
                            input logic [19:0] chg, input logic [19:0] dis);
    write_reg(REG_START, 20'(st));
    write_reg(REG_STOP, 20'(sp));
    write_reg(REG_CHG_LIMIT, chg);
    write_reg(REG_DIS_LIMIT, dis);
    cfg_settings++;
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned stop_at;
    int          pick;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) send_kind(FR_GOOD);
      else if (pick < 62) send_kind(FR_BAD_START);
      else if (pick < 69) send_kind(FR_ERR_STATUS);
      else if (pick < 76) send_kind(FR_BAD_CSUM);
      else if (pick < 83) send_kind(FR_BAD_STOP);
      else if (pick < 90) send_kind(FR_SHORT);
      else if (pick < 95) send_kind(FR_LONG);
      else send_kind(FR_NOISE);
    end
  endtask

  task automatic random_config();
    set_config(8'($urandom), 8'($urandom), 20'($urandom_range(0, 1000000)),
               20'($urandom_range(0, 1000000)));
  endtask

  initial begin
    byte_q_t one;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = '0;
    in_frame_end = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_START;
    cfg_wdata    = '0;
    hold_req     = 1'b0;
    bytes_sent   = 0;
    cfg_settings = 1;
    in_idle_pct  = 35;
    out_idle_pct = 80;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed frames at reset settings
    one.insert(0, START_RST);
    send_frame(one);
    send_fields(8'hFF, 8'hFF);
    send_fields(8'h00, 8'h00);
    send_fields(8'h80, 8'h00);
    send_fields(8'h7F, 8'hFF);
    send_kind(FR_BAD_START);
    send_kind(FR_ERR_STATUS);
    send_kind(FR_BAD_CSUM);
    send_kind(FR_BAD_STOP);
    send_kind(FR_SHORT);
    send_kind(FR_LONG);
    send_kind(FR_GOOD);
    drain();

    set_config(8'h00, 8'hFF, 20'd1000000, 20'd0);
    random_traffic(PHASE_BYTES);
    drain();
    set_config(8'hFF, 8'h00, 20'd0, 20'd1000000);
    random_traffic(PHASE_BYTES);
    drain();

    in_idle_pct  = 80;
    out_idle_pct = 35;
    random_config();
    random_traffic(PHASE_BYTES);
    drain();
    random_config();
    random_traffic(PHASE_BYTES);
    drain();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_config(START_RST, STOP_RST, 20'd1000000, 20'd1000000);
    // long receiver hold-off while bytes keep coming
    hold_req = 1'b1;
    random_traffic(PHASE_BYTES);
    drain();
    random_config();
    random_traffic(PHASE_BYTES);
    drain();

    $display("run: %0d bytes in, %0d frames checked (%0d accepted, %0d rejected)",
             bytes_sent, sb.checked, sb.passed, sb.checked - sb.passed);
    $display("run: %0d marker/limit settings, %0d mismatches", cfg_settings, sb.errors);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/bifc_pkg.sv
hdl/bifc_front.sv
hdl/bifc_queue.sv
hdl/bifc_back.sv
hdl/bms_info_frame_checker.sv
tb/tb_bms_info_frame_checker.sv
